/* hdl/dama_pkg.sv */
`timescale 1ns / 1ps

package dama_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned TEMP_W    = 10;
  localparam int unsigned MEAN_W    = 12;
  localparam int unsigned CNT_OUT_W = 4;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Magnitude of the difference of two temperatures fits in TEMP_W bits.
  localparam int unsigned MAG_W = TEMP_W;

  // Defaults for the top-level parameters.
  localparam int unsigned DEPTH_DEF       = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Register values after reset.
  localparam logic [RAW_W-1:0]         RST_MIN_RAW  = 12'd1061;
  localparam logic [RAW_W-1:0]         RST_MAX_RAW  = 12'd2049;
  localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP = -10'sd10;
  localparam logic signed [TEMP_W-1:0] RST_MAX_TEMP = 10'sd140;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RAW  = 2'd0,
    CFG_MAX_RAW  = 2'd1,
    CFG_MIN_TEMP = 2'd2,
    CFG_MAX_TEMP = 2'd3
  } cfg_idx_e;

endpackage

/* hdl/dama_div.sv */
`timescale 1ns / 1ps

module dama_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW);
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // One restoring step: bring in the next dividend bit and try the subtraction.
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift registers for the remainder and the dividend turning into the quotient.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/dual_adc_moving_average_temp.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
// samples   in         in_valid_i/in_stall_o   raw_one_i, raw_two_i, channel_i
// results   out        out_valid_o/out_stall_i mean_raw_o, temperature_o, sample_count_o
//
// One item at a time. An item on the temperature line goes through the bit-serial divider for
// the mean, the bit-serial multiplier and the two bit-serial dividers for the line, each one
// bit per cycle; an item that clamps goes through the divider for the mean only.
// Reset clears the sums, the ring pointer, the control state and the configuration registers;
// ring contents and datapath registers are not cleared.
// A new sample is taken while a finished result still waits; a stall on the result side
// only holds the block once the next result is ready.

module dual_adc_moving_average_temp #(
  parameter int unsigned DEPTH       = dama_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = dama_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dama_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dama_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dama_pkg::RAW_W-1:0]          raw_one_i,
  input  logic [dama_pkg::RAW_W-1:0]          raw_two_i,
  input  logic                                channel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dama_pkg::MEAN_W-1:0]         mean_raw_o,
  output logic signed [dama_pkg::TEMP_W-1:0]  temperature_o,
  output logic [dama_pkg::CNT_OUT_W-1:0]      sample_count_o
);

  import dama_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = SAMPLE_BITS + $clog2(DEPTH);
  localparam int unsigned MC_W      = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam int unsigned PROD_W    = MC_W + MAG_W;
  localparam int unsigned T_W       = PROD_W + 2;
  localparam int unsigned MUL_CNT_W = $clog2(MAG_W);

  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]     FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST  = MUL_CNT_W'(MAG_W - 1);
  localparam logic signed [T_W-1:0] T_HI     = T_W'((1 << (TEMP_W - 1)) - 1);
  localparam logic signed [T_W-1:0] T_LO     = T_W'(-(1 << (TEMP_W - 1)));

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MEAN = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_LINE = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [RAW_W-1:0]         min_raw_q, max_raw_q;
  logic signed [TEMP_W-1:0] min_temp_q, max_temp_q;

  // Ring and running sums.
  logic [SAMPLE_BITS-1:0] ring_one_q [DEPTH];
  logic [SAMPLE_BITS-1:0] ring_two_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_one_q, rd_two_q;
  logic                   ring_we;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic                   full_q, full_d;
  logic [SUM_W-1:0]       sum_one_q, sum_one_d, sum_two_q, sum_two_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  // Captured sample.
  logic [SAMPLE_BITS-1:0] smp_one_q, smp_two_q;
  logic                   sel_q;
  logic                   in_take;

  // Mean, clamp and line datapath.
  logic [MC_W-1:0]          avg_q, avg_d;
  logic signed [TEMP_W-1:0] clamp_q, clamp_d;
  logic                     use_clamp_q, use_clamp_d;
  logic                     neg_q, neg_d;
  logic [MAG_W-1:0]         mplr_q, mplr_d;
  logic [PROD_W-1:0]        acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [MUL_CNT_W-1:0]     mul_cnt_q, mul_cnt_d;

  logic signed [TEMP_W:0]   span_t;
  logic [TEMP_W:0]          span_abs;
  logic [RAW_W-1:0]         span_ad;

  // Divider handshakes.
  logic              mean_start, mean_done;
  logic [SUM_W-1:0]  mean_quo;
  logic              line_start, line_done_a, line_done_b;
  logic [PROD_W-1:0] quo_a, quo_b;

  // Result stage.
  logic signed [T_W-1:0]    t_line;
  logic signed [TEMP_W-1:0] t_sat, temp_fin;
  logic                     out_load;
  logic                     out_valid_q;
  logic [MEAN_W-1:0]        mean_out_q;
  logic signed [TEMP_W-1:0] temp_out_q;
  logic [CNT_OUT_W-1:0]     cnt_out_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_raw_q  <= RST_MIN_RAW;
      max_raw_q  <= RST_MAX_RAW;
      min_temp_q <= RST_MIN_TEMP;
      max_temp_q <= RST_MAX_TEMP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RAW:  min_raw_q  <= cfg_wdata_i[RAW_W-1:0];
        CFG_MAX_RAW:  max_raw_q  <= cfg_wdata_i[RAW_W-1:0];
        CFG_MIN_TEMP: min_temp_q <= cfg_wdata_i[TEMP_W-1:0];
        CFG_MAX_TEMP: max_temp_q <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Spans of the temperature line.
  assign span_t   = {max_temp_q[TEMP_W-1], max_temp_q} - {min_temp_q[TEMP_W-1], min_temp_q};
  assign span_abs = span_t[TEMP_W] ? (~span_t + 1'b1) : span_t;
  assign span_ad  = max_raw_q - min_raw_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    full_d      = full_q;
    sum_one_d   = sum_one_q;
    sum_two_d   = sum_two_q;
    cnt_d       = cnt_q;
    avg_d       = avg_q;
    clamp_d     = clamp_q;
    use_clamp_d = use_clamp_q;
    neg_d       = neg_q;
    mplr_d      = mplr_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    mul_cnt_d   = mul_cnt_q;
    ring_we     = 1'b0;
    mean_start  = 1'b0;
    line_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // The oldest entry leaves the sum only once the ring has wrapped.
        ring_we   = 1'b1;
        sum_one_d = sum_one_q - (full_q ? SUM_W'(rd_one_q) : '0) + SUM_W'(smp_one_q);
        sum_two_d = sum_two_q - (full_q ? SUM_W'(rd_two_q) : '0) + SUM_W'(smp_two_q);
        if (slot_q == LAST_SLOT) begin
          slot_d = '0;
          full_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        cnt_d      = full_d ? FULL_CNT : CNT_W'(slot_d);
        mean_start = 1'b1;
        state_d    = ST_MEAN;
      end
      ST_MEAN: begin
        if (mean_done) begin
          avg_d = MC_W'(mean_quo);
          // The low clamp is tested first, so reversed bounds never divide.
          if (avg_d <= MC_W'(min_raw_q)) begin
            clamp_d     = min_temp_q;
            use_clamp_d = 1'b1;
            state_d     = ST_FIN;
          end else if (avg_d >= MC_W'(max_raw_q)) begin
            clamp_d     = max_temp_q;
            use_clamp_d = 1'b1;
            state_d     = ST_FIN;
          end else begin
            use_clamp_d = 1'b0;
            neg_d       = span_t[TEMP_W];
            mplr_d      = span_abs[MAG_W-1:0];
            acc_a_d     = '0;
            acc_b_d     = '0;
            mul_cnt_d   = '0;
            state_d     = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // Shift-and-add, most significant multiplier bit first, both products at once.
        acc_a_d   = {acc_a_q[PROD_W-2:0], 1'b0} + (mplr_q[MAG_W-1] ? PROD_W'(avg_q) : '0);
        acc_b_d   = {acc_b_q[PROD_W-2:0], 1'b0} + (mplr_q[MAG_W-1] ? PROD_W'(min_raw_q) : '0);
        mplr_d    = {mplr_q[MAG_W-2:0], 1'b0};
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == MUL_LAST) begin
          line_start = 1'b1;
          state_d    = ST_LINE;
        end
      end
      ST_LINE: begin
        if (line_done_a) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      full_q    <= 1'b0;
      sum_one_q <= '0;
      sum_two_q <= '0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      full_q    <= full_d;
      sum_one_q <= sum_one_d;
      sum_two_q <= sum_two_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    avg_q       <= avg_d;
    clamp_q     <= clamp_d;
    use_clamp_q <= use_clamp_d;
    neg_q       <= neg_d;
    mplr_q      <= mplr_d;
    acc_a_q     <= acc_a_d;
    acc_b_q     <= acc_b_d;
    mul_cnt_q   <= mul_cnt_d;
    if (in_take) begin
      smp_one_q <= SAMPLE_BITS'(raw_one_i);
      smp_two_q <= SAMPLE_BITS'(raw_two_i);
      sel_q     <= channel_i;
    end
  end

  // Sample rings: one registered read and one write at the current slot.
  always_ff @(posedge clk_i) begin
    rd_one_q <= ring_one_q[slot_q];
    rd_two_q <= ring_two_q[slot_q];
    if (ring_we) begin
      ring_one_q[slot_q] <= smp_one_q;
      ring_two_q[slot_q] <= smp_two_q;
    end
  end

  // Mean of the selected channel.
  dama_div #(
    .NW (SUM_W),
    .DW (CNT_W)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mean_start),
    .dividend_i (sel_q ? sum_two_d : sum_one_d),
    .divisor_i  (cnt_d),
    .done_o     (mean_done),
    .quotient_o (mean_quo)
  );

  // Two line terms, divided side by side by the raw span.
  dama_div #(
    .NW (PROD_W),
    .DW (RAW_W)
  ) u_line_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (line_start),
    .dividend_i (acc_a_d),
    .divisor_i  (span_ad),
    .done_o     (line_done_a),
    .quotient_o (quo_a)
  );

  dama_div #(
    .NW (PROD_W),
    .DW (RAW_W)
  ) u_line_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (line_start),
    .dividend_i (acc_b_d),
    .divisor_i  (span_ad),
    .done_o     (line_done_b),
    .quotient_o (quo_b)
  );

  // Both quotients truncate toward zero on magnitudes; the signs follow the temperature span.
  always_comb begin
    t_line = T_W'(min_temp_q) +
             (neg_q ? (T_W'(quo_b) - T_W'(quo_a)) : (T_W'(quo_a) - T_W'(quo_b)));
    if (t_line > T_HI) begin
      t_sat = TEMP_W'(T_HI);
    end else if (t_line < T_LO) begin
      t_sat = TEMP_W'(T_LO);
    end else begin
      t_sat = TEMP_W'(t_line);
    end
    temp_fin = use_clamp_q ? clamp_q : t_sat;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_out_q <= MEAN_W'(avg_q);
      temp_out_q <= temp_fin;
      cnt_out_q  <= CNT_OUT_W'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_raw_o     = mean_out_q;
  assign temperature_o  = temp_out_q;
  assign sample_count_o = cnt_out_q;

  // The mean divider only finishes while the sequencer waits for it.
  a_mean_done_in_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_done |-> (state_q == ST_MEAN))
    else $error("mean divider finished outside the mean state");

  // The two line dividers run in lockstep.
  a_line_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_done_a == line_done_b)
    else $error("line dividers out of step");

  // A new result only appears after the final state.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result loaded outside the final state");

endmodule
